// ===== src/rmd_pkg.sv =====
// rmd_pkg: constants, register codes, stage payload type and table
// helpers for the ripple mesh displacement pipeline.
// No dependencies.
package rmd_pkg;

   // Screen geometry and number format
   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;
   localparam int CELL_PITCH    = 8;
   localparam int FRACTION_BITS = 16;
   localparam int Q30_SHIFT     = 30 - FRACTION_BITS;

   // Q30 angle constants
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // pi and 2*pi rounded to the working fraction
   localparam longint PI_F     = (PI_Q30 + (64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
   localparam longint TWO_PI_F = (TWO_PI_Q30 + (64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;

   // Pipeline shape
   localparam int ROOT_STEPS   = 32;
   localparam int ROOT_PER     = 2;
   localparam int MOD_STEPS    = 30;
   localparam int MOD_PER      = 3;
   localparam int HORNER_TERMS = 6;
   localparam int DIV_SHIFT    = 34;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_CENTRE_X   = 2'd0,
      CSR_CENTRE_Y   = 2'd1,
      CSR_RING_SCALE = 2'd2,
      CSR_STRENGTH   = 2'd3
   } csr_index_type;

   // Everything an item carries down the pipeline
   typedef struct packed {
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [63:0]        sqx;
      logic [63:0]        sqy;
      logic [63:0]        rad;
      logic [34:0]        rem;
      logic [31:0]        root;
      logic signed [64:0] dprod;
      logic               in_ripple;
      logic [47:0]        m;
      logic [30:0]        t;
      logic               neg;
      logic [61:0]        tsq;
      logic [31:0]        t2;
      logic signed [31:0] term;
      logic signed [64:0] hprod;
      logic [33:0]        ha;
      logic               hneg;
      logic [67:0]        hq;
      logic signed [33:0] opcs;
      logic signed [19:0] opc;
      logic signed [51:0] mprod;
      logic signed [31:0] mul;
      logic signed [63:0] pu;
      logic signed [63:0] pv;
      logic signed [48:0] ru;
      logic signed [48:0] rv;
      logic signed [31:0] uo;
      logic signed [31:0] vo;
   } pl_type;

   // Divisors of the cosine series, innermost first
   function automatic int series_div(input int i);
      int d;
      case (i)
         0:       d = 132;
         1:       d = 90;
         2:       d = 56;
         3:       d = 30;
         4:       d = 12;
         default: d = 2;
      endcase
      return d;
   endfunction

   // Grid index to centred offset divided by the screen width, in Q(F), rounded, ties away from zero
   function automatic logic signed [31:0] grid_pos(input int idx, input int half);
      longint n;
      longint a;
      longint q;
      n = (longint'(idx) * CELL_PITCH - half) * (64'sd1 <<< FRACTION_BITS);
      a = (n < 0) ? -n : n;
      q = (a + SCREEN_WIDTH / 2) / SCREEN_WIDTH;
      return 32'((n < 0) ? -q : q);
   endfunction

endpackage

// ===== src/ripple_mesh_displace.sv =====
// Ripple mesh displacement: 65 register stages from req accept to rsp valid.
// Throughput one item per cycle; the whole pipeline holds
// while a finished item waits on rsp_ready. The square root (two bits per
// stage), the 2*pi reduction (three bits per stage) and six series terms (four
// stages each) set the depth. Reset (synchronous) empties the pipeline and
// loads the register reset values.
// Holds the top level; depends on rmd_pkg.
module ripple_mesh_displace (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [6:0]         req_column,
   input  logic [5:0]         req_row,
   input  logic signed [31:0] req_u_in,
   input  logic signed [31:0] req_v_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_u_out,
   output logic signed [31:0] rsp_v_out,
   output logic               rsp_inside_res,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int ROOT_STAGES = rmd_pkg::ROOT_STEPS / rmd_pkg::ROOT_PER;
   localparam int MOD_STAGES  = rmd_pkg::MOD_STEPS / rmd_pkg::MOD_PER;
   localparam int ST_POS   = 0;
   localparam int ST_SQ    = 1;
   localparam int ST_RAD   = 2;
   localparam int ST_ROOT  = 3;
   localparam int ST_DPROD = ST_ROOT + ROOT_STAGES;
   localparam int ST_DIST  = ST_DPROD + 1;
   localparam int ST_MOD   = ST_DIST + 1;
   localparam int ST_FOLD  = ST_MOD + MOD_STAGES;
   localparam int ST_TSQ   = ST_FOLD + 1;
   localparam int ST_T2    = ST_TSQ + 1;
   localparam int ST_HORN  = ST_T2 + 1;
   localparam int ST_OPCS  = ST_HORN + 4 * rmd_pkg::HORNER_TERMS;
   localparam int ST_OPC   = ST_OPCS + 1;
   localparam int ST_MPROD = ST_OPC + 1;
   localparam int ST_MUL   = ST_MPROD + 1;
   localparam int ST_PROD  = ST_MUL + 1;
   localparam int ST_RND   = ST_PROD + 1;
   localparam int ST_SUM   = ST_RND + 1;
   localparam int N_STAGE  = ST_SUM + 1;
   localparam int SH       = rmd_pkg::Q30_SHIFT;
   localparam int FB       = rmd_pkg::FRACTION_BITS;
   localparam int R_BITS   = $clog2(rmd_pkg::TWO_PI_F);

   localparam logic signed [35:0] PI36      = 36'(rmd_pkg::PI_Q30);
   localparam logic signed [35:0] TWO_PI36  = 36'(rmd_pkg::TWO_PI_Q30);
   localparam logic signed [35:0] HALF_PI36 = 36'(rmd_pkg::HALF_PI_Q30);
   localparam logic signed [35:0] ONE36     = 36'(rmd_pkg::ONE_Q30);

   // Configuration registers
   logic signed [31:0] centre_x_ff;
   logic signed [31:0] centre_y_ff;
   logic signed [31:0] ring_scale_ff;
   logic signed [31:0] strength_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff   <= '0;
         centre_y_ff   <= '0;
         ring_scale_ff <= 32'sd65536;
         strength_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            rmd_pkg::CSR_CENTRE_X:   centre_x_ff   <= csr_wdata;
            rmd_pkg::CSR_CENTRE_Y:   centre_y_ff   <= csr_wdata;
            rmd_pkg::CSR_RING_SCALE: ring_scale_ff <= csr_wdata;
            rmd_pkg::CSR_STRENGTH:   strength_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline registers and global advance
   rmd_pkg::pl_type pl_ff [N_STAGE];
   rmd_pkg::pl_type pl_in [N_STAGE];
   logic [N_STAGE-1:0] vld_ff;
   logic [N_STAGE-1:0] vld_in;
   logic               en;

   assign en        = !vld_ff[N_STAGE-1] || rsp_ready;
   assign req_ready = en;
   assign vld_in    = {vld_ff[N_STAGE-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff <= pl_in;
      end
   end

   // Grid position tables
   logic signed [31:0] xtab [128];
   logic signed [31:0] ytab [64];

   for (genvar gi = 0; gi < 128; gi++) begin : g_xtab
      assign xtab[gi] = rmd_pkg::grid_pos(gi, rmd_pkg::SCREEN_WIDTH / 2);
   end
   for (genvar gi = 0; gi < 64; gi++) begin : g_ytab
      assign ytab[gi] = rmd_pkg::grid_pos(gi, rmd_pkg::SCREEN_HEIGHT / 2);
   end

   // Offsets from the centre, saturated
   always_comb begin : s_pos
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      pl_in[ST_POS] = '0;
      dx = 33'(xtab[req_column]) - 33'(centre_x_ff);
      dy = 33'(ytab[req_row]) - 33'(centre_y_ff);
      pl_in[ST_POS].u = req_u_in;
      pl_in[ST_POS].v = req_v_in;
      if (dx[32] != dx[31]) begin
         pl_in[ST_POS].cx = dx[32] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         pl_in[ST_POS].cx = dx[31:0];
      end
      if (dy[32] != dy[31]) begin
         pl_in[ST_POS].cy = dy[32] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         pl_in[ST_POS].cy = dy[31:0];
      end
   end

   // Squares
   always_comb begin : s_sq
      logic signed [63:0] qx;
      logic signed [63:0] qy;
      pl_in[ST_SQ] = pl_ff[ST_SQ-1];
      qx = pl_ff[ST_SQ-1].cx * pl_ff[ST_SQ-1].cx;
      qy = pl_ff[ST_SQ-1].cy * pl_ff[ST_SQ-1].cy;
      pl_in[ST_SQ].sqx = qx;
      pl_in[ST_SQ].sqy = qy;
   end

   // Radius squared
   always_comb begin : s_rad
      pl_in[ST_RAD] = pl_ff[ST_RAD-1];
      pl_in[ST_RAD].rad  = pl_ff[ST_RAD-1].sqx + pl_ff[ST_RAD-1].sqy;
      pl_in[ST_RAD].rem  = '0;
      pl_in[ST_RAD].root = '0;
   end

   // Square root, two result bits per stage
   for (genvar gs = 0; gs < ROOT_STAGES; gs++) begin : g_root
      always_comb begin : s_root
         logic [36:0] rt;
         logic [36:0] trial;
         rmd_pkg::pl_type p;
         p = pl_ff[ST_ROOT+gs-1];
         for (int i = 0; i < rmd_pkg::ROOT_PER; i++) begin
            rt    = {p.rem, p.rad[63:62]};
            trial = {3'b000, p.root, 2'b01};
            if (rt >= trial) begin
               p.rem  = 35'(rt - trial);
               p.root = {p.root[30:0], 1'b1};
            end else begin
               p.rem  = rt[34:0];
               p.root = {p.root[30:0], 1'b0};
            end
            p.rad = {p.rad[61:0], 2'b00};
         end
         pl_in[ST_ROOT+gs] = p;
      end
   end

   // Magnitude times ring scale
   always_comb begin : s_dprod
      pl_in[ST_DPROD] = pl_ff[ST_DPROD-1];
      pl_in[ST_DPROD].dprod = $signed({1'b0, pl_ff[ST_DPROD-1].root}) * ring_scale_ff;
   end

   // Scaled distance, inside test
   always_comb begin : s_dist
      logic [64:0] mg;
      logic [64:0] sm;
      pl_in[ST_DIST] = pl_ff[ST_DIST-1];
      mg = pl_ff[ST_DIST-1].dprod[64] ? 65'(-pl_ff[ST_DIST-1].dprod)
                                       : 65'(pl_ff[ST_DIST-1].dprod);
      sm = mg + (65'd1 << (FB - 1));
      pl_in[ST_DIST].m         = 48'(sm >> FB);
      pl_in[ST_DIST].in_ripple = pl_ff[ST_DIST-1].dprod[64] ||
                                 (48'(sm >> FB) < 48'(rmd_pkg::PI_F));
   end

   // Reduction modulo 2*pi, restoring steps
   for (genvar gm = 0; gm < MOD_STAGES; gm++) begin : g_mod
      always_comb begin : s_mod
         logic [48:0] cand;
         rmd_pkg::pl_type p;
         p = pl_ff[ST_MOD+gm-1];
         for (int i = 0; i < rmd_pkg::MOD_PER; i++) begin
            cand = 49'(rmd_pkg::TWO_PI_F) <<
                   (rmd_pkg::MOD_STEPS - 1 - (rmd_pkg::MOD_PER * gm + i));
            if ({1'b0, p.m} >= cand) begin
               p.m = 48'({1'b0, p.m} - cand);
            end
         end
         pl_in[ST_MOD+gm] = p;
      end
   end

   // Fold angle into the first quadrant
   always_comb begin : s_fold
      logic signed [35:0] tt;
      pl_in[ST_FOLD] = pl_ff[ST_FOLD-1];
      tt = $signed(36'(pl_ff[ST_FOLD-1].m[R_BITS-1:0]) << SH);
      if (tt > PI36) begin
         tt = TWO_PI36 - tt;
      end
      if (tt < 0) begin
         tt = '0;
      end
      pl_in[ST_FOLD].neg = 1'b0;
      if (tt > HALF_PI36) begin
         tt = PI36 - tt;
         pl_in[ST_FOLD].neg = 1'b1;
      end
      pl_in[ST_FOLD].t = tt[30:0];
   end

   // Angle squared
   always_comb begin : s_tsq
      pl_in[ST_TSQ] = pl_ff[ST_TSQ-1];
      pl_in[ST_TSQ].tsq = 62'(pl_ff[ST_TSQ-1].t) * 62'(pl_ff[ST_TSQ-1].t);
   end

   always_comb begin : s_t2
      logic [62:0] sm;
      pl_in[ST_T2] = pl_ff[ST_T2-1];
      sm = {1'b0, pl_ff[ST_T2-1].tsq} + (63'd1 << 29);
      pl_in[ST_T2].t2   = 32'(sm >> 30);
      pl_in[ST_T2].term = 32'(rmd_pkg::ONE_Q30);
   end

   // Cosine series, four stages per term
   for (genvar gh = 0; gh < rmd_pkg::HORNER_TERMS; gh++) begin : g_horn
      localparam int DIV = rmd_pkg::series_div(gh);
      localparam logic [33:0] RECIP =
         34'((64'd1 << rmd_pkg::DIV_SHIFT) / rmd_pkg::series_div(gh));
      localparam int B = ST_HORN + 4 * gh;

      // product with running term
      always_comb begin : s_hmul
         pl_in[B] = pl_ff[B-1];
         pl_in[B].hprod = $signed({1'b0, pl_ff[B-1].t2}) * pl_ff[B-1].term;
      end

      // round to Q30 in sign-magnitude
      always_comb begin : s_hrnd
         logic [64:0] mg;
         logic [64:0] sm;
         pl_in[B+1] = pl_ff[B];
         mg = pl_ff[B].hprod[64] ? 65'(-pl_ff[B].hprod) : 65'(pl_ff[B].hprod);
         sm = mg + (65'd1 << 29);
         pl_in[B+1].ha   = 34'(sm >> 30);
         pl_in[B+1].hneg = pl_ff[B].hprod[64];
      end

      // reciprocal estimate of the quotient
      always_comb begin : s_hrcp
         pl_in[B+2] = pl_ff[B+1];
         pl_in[B+2].hq = 68'(pl_ff[B+1].ha) * 68'(RECIP);
      end

      // correct quotient, next term
      always_comb begin : s_hcor
         logic [33:0]        q;
         logic [41:0]        qd;
         logic [41:0]        r;
         logic signed [35:0] ts;
         pl_in[B+3] = pl_ff[B+2];
         q  = pl_ff[B+2].hq[2*rmd_pkg::DIV_SHIFT-1 -: 34];
         qd = {8'b0, q} * 42'(DIV);
         r  = {8'b0, pl_ff[B+2].ha} - qd;
         if (r >= 42'(DIV)) begin
            q = q + 34'd1;
         end
         ts = pl_ff[B+2].hneg ? ONE36 + $signed({2'b00, q})
                              : ONE36 - $signed({2'b00, q});
         pl_in[B+3].term = ts[31:0];
      end
   end

   // One plus cosine
   always_comb begin : s_opcs
      logic signed [33:0] tm;
      pl_in[ST_OPCS] = pl_ff[ST_OPCS-1];
      tm = 34'(pl_ff[ST_OPCS-1].term);
      pl_in[ST_OPCS].opcs = 34'(ONE36) + (pl_ff[ST_OPCS-1].neg ? -tm : tm);
   end

   always_comb begin : s_opc
      logic signed [33:0] tmp;
      pl_in[ST_OPC] = pl_ff[ST_OPC-1];
      tmp = pl_ff[ST_OPC-1].opcs + (34'sd1 <<< (SH - 1))
            - $signed({33'b0, pl_ff[ST_OPC-1].opcs[33]});
      pl_in[ST_OPC].opc = 20'(tmp >>> SH);
   end

   // Gain
   always_comb begin : s_mprod
      pl_in[ST_MPROD] = pl_ff[ST_MPROD-1];
      pl_in[ST_MPROD].mprod = pl_ff[ST_MPROD-1].opc * strength_ff;
   end

   always_comb begin : s_mul
      logic signed [51:0] tmp;
      logic signed [51:0] r;
      pl_in[ST_MUL] = pl_ff[ST_MUL-1];
      tmp = pl_ff[ST_MUL-1].mprod + (52'sd1 <<< (FB - 1))
            - $signed({51'b0, pl_ff[ST_MUL-1].mprod[51]});
      r = tmp >>> FB;
      if (r > 52'sd2147483647) begin
         pl_in[ST_MUL].mul = 32'sh7fffffff;
      end else if (r < -52'sd2147483648) begin
         pl_in[ST_MUL].mul = 32'sh80000000;
      end else begin
         pl_in[ST_MUL].mul = r[31:0];
      end
   end

   // Displacement products
   always_comb begin : s_prod
      pl_in[ST_PROD] = pl_ff[ST_PROD-1];
      pl_in[ST_PROD].pu = pl_ff[ST_PROD-1].cx * pl_ff[ST_PROD-1].mul;
      pl_in[ST_PROD].pv = pl_ff[ST_PROD-1].cy * pl_ff[ST_PROD-1].mul;
   end

   always_comb begin : s_rnd
      logic signed [63:0] tu;
      logic signed [63:0] tv;
      pl_in[ST_RND] = pl_ff[ST_RND-1];
      tu = pl_ff[ST_RND-1].pu + (64'sd1 <<< (FB - 1))
           - $signed({63'b0, pl_ff[ST_RND-1].pu[63]});
      tv = pl_ff[ST_RND-1].pv + (64'sd1 <<< (FB - 1))
           - $signed({63'b0, pl_ff[ST_RND-1].pv[63]});
      pl_in[ST_RND].ru = 49'(tu >>> FB);
      pl_in[ST_RND].rv = 49'(tv >>> FB);
   end

   // Saturating add, pass-through outside the ripple
   always_comb begin : s_sum
      logic signed [49:0] su;
      logic signed [49:0] sv;
      logic signed [31:0] du;
      logic signed [31:0] dv;
      pl_in[ST_SUM] = pl_ff[ST_SUM-1];
      su = 50'(pl_ff[ST_SUM-1].u) + 50'(pl_ff[ST_SUM-1].ru);
      sv = 50'(pl_ff[ST_SUM-1].v) + 50'(pl_ff[ST_SUM-1].rv);
      if (su > 50'sd2147483647) begin
         du = 32'sh7fffffff;
      end else if (su < -50'sd2147483648) begin
         du = 32'sh80000000;
      end else begin
         du = su[31:0];
      end
      if (sv > 50'sd2147483647) begin
         dv = 32'sh7fffffff;
      end else if (sv < -50'sd2147483648) begin
         dv = 32'sh80000000;
      end else begin
         dv = sv[31:0];
      end
      pl_in[ST_SUM].uo = pl_ff[ST_SUM-1].in_ripple ? du : pl_ff[ST_SUM-1].u;
      pl_in[ST_SUM].vo = pl_ff[ST_SUM-1].in_ripple ? dv : pl_ff[ST_SUM-1].v;
   end

   // Result port
   assign rsp_valid      = vld_ff[N_STAGE-1];
   assign rsp_u_out      = pl_ff[N_STAGE-1].uo;
   assign rsp_v_out      = pl_ff[N_STAGE-1].vo;
   assign rsp_inside_res = pl_ff[N_STAGE-1].in_ripple;

   // Checks
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[ST_POS])
      else $error("accepted item missing from first stage");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   a_fold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_FOLD] |-> (36'(pl_ff[ST_FOLD].t) <= HALF_PI36))
      else $error("folded angle beyond quarter turn");

   a_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |-> (rsp_u_out == pl_ff[N_STAGE-1].u) &&
                                       (rsp_v_out == pl_ff[N_STAGE-1].v))
      else $error("outside item was displaced");

endmodule
